FILE: design/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Shared types and constants for the NEC IR pulse decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

    localparam int TIME_W        = 16;
    localparam int CMD_W         = 8;
    localparam int CNT_W         = 8;
    localparam int FRAME_SYMBOLS = 32;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_HIGH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH = 3'd6;

    localparam logic [TIME_W-1:0] RST_ZERO_LOW    = 16'h0300;
    localparam logic [TIME_W-1:0] RST_ZERO_HIGH   = 16'h04F0;
    localparam logic [TIME_W-1:0] RST_ONE_LOW     = 16'h0A00;
    localparam logic [TIME_W-1:0] RST_ONE_HIGH    = 16'h0E80;
    localparam logic [TIME_W-1:0] RST_REPEAT_HIGH = 16'h1F00;
    localparam logic [TIME_W-1:0] RST_LEADER_LOW  = 16'h1C00;
    localparam logic [TIME_W-1:0] RST_LEADER_HIGH = 16'h2400;

    typedef enum logic [1:0] {
        CLS_ZERO    = 2'd0,
        CLS_ONE     = 2'd1,
        CLS_REPEAT  = 2'd2,
        CLS_UNKNOWN = 2'd3
    } t_cls;

    typedef struct packed {
        logic [TIME_W-1:0] zero_low;
        logic [TIME_W-1:0] zero_high;
        logic [TIME_W-1:0] one_low;
        logic [TIME_W-1:0] one_high;
        logic [TIME_W-1:0] repeat_high;
        logic [TIME_W-1:0] leader_low;
        logic [TIME_W-1:0] leader_high;
    } t_cfg;

    // decoded edge event handed from front to back
    typedef struct packed {
        logic timeout;
        logic measure;
        t_cls cls;
        logic leader;
    } t_op;

endpackage

FILE: design/nec_ir_if.sv
// ----------------------------------------------------------------------------
// nec_ir_in_if / nec_ir_out_if
// Valid/ready channels for edge items and decoded result items.
// ----------------------------------------------------------------------------
interface nec_ir_in_if;
    import nec_ir_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TIME_W-1:0] edge_time;

    modport source(output valid, opcode, edge_time, input ready);
    modport sink(input valid, opcode, edge_time, output ready);
endinterface

interface nec_ir_out_if;
    import nec_ir_pkg::*;

    logic             valid;
    logic             ready;
    logic             frame_done;
    logic             frame_complete;
    logic [CMD_W-1:0] command;
    logic             command_ok;
    logic             repeat_seen;
    logic [CNT_W-1:0] repeat_count;

    modport source(output valid, frame_done, frame_complete, command, command_ok,
                   repeat_seen, repeat_count, input ready);
    modport sink(input valid, frame_done, frame_complete, command, command_ok,
                 repeat_seen, repeat_count, output ready);
endinterface

FILE: design/nec_ir_regs.sv
// ----------------------------------------------------------------------------
// nec_ir_regs
// APB register file holding the interval classification windows.
// ----------------------------------------------------------------------------
module nec_ir_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nec_ir_pkg::APB_AW-1:0] paddr,
    input  logic [nec_ir_pkg::APB_DW-1:0] pwdata,
    output logic [nec_ir_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output nec_ir_pkg::t_cfg              o_cfg
);
    import nec_ir_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    rd_val;
    logic [TIME_W-1:0]    wd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_AW-1:2];
    assign wd     = pwdata[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_low    <= RST_ZERO_LOW;
            r_cfg.zero_high   <= RST_ZERO_HIGH;
            r_cfg.one_low     <= RST_ONE_LOW;
            r_cfg.one_high    <= RST_ONE_HIGH;
            r_cfg.repeat_high <= RST_REPEAT_HIGH;
            r_cfg.leader_low  <= RST_LEADER_LOW;
            r_cfg.leader_high <= RST_LEADER_HIGH;
        end else if (wr_en) begin
            unique case (idx)
                REG_ZERO_LOW:    r_cfg.zero_low    <= wd;
                REG_ZERO_HIGH:   r_cfg.zero_high   <= wd;
                REG_ONE_LOW:     r_cfg.one_low     <= wd;
                REG_ONE_HIGH:    r_cfg.one_high    <= wd;
                REG_REPEAT_HIGH: r_cfg.repeat_high <= wd;
                REG_LEADER_LOW:  r_cfg.leader_low  <= wd;
                REG_LEADER_HIGH: r_cfg.leader_high <= wd;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ZERO_LOW:    rd_val = r_cfg.zero_low;
            REG_ZERO_HIGH:   rd_val = r_cfg.zero_high;
            REG_ONE_LOW:     rd_val = r_cfg.one_low;
            REG_ONE_HIGH:    rd_val = r_cfg.one_high;
            REG_REPEAT_HIGH: rd_val = r_cfg.repeat_high;
            REG_LEADER_LOW:  rd_val = r_cfg.leader_low;
            REG_LEADER_HIGH: rd_val = r_cfg.leader_high;
            default:         rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DW-TIME_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

FILE: design/nec_ir_front.sv
// ----------------------------------------------------------------------------
// nec_ir_front
// Accepts edge items, tracks edge parity and start time, classifies intervals.
// ----------------------------------------------------------------------------
module nec_ir_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nec_ir_pkg::t_cfg  i_cfg,
    nec_ir_in_if.sink         i_item,
    input  logic              i_full,
    output logic              o_push,
    output nec_ir_pkg::t_op   o_op
);
    import nec_ir_pkg::*;

    logic              r_parity;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] dt;
    logic              accept;
    logic              is_edge;
    t_cls              cls;

    function automatic t_cls classify(input t_cfg c, input logic [TIME_W-1:0] t);
        priority if (c.zero_low < t && t < c.zero_high) return CLS_ZERO;
        else if (c.one_low < t && t < c.one_high) return CLS_ONE;
        else if (c.one_high < t && t < c.repeat_high) return CLS_REPEAT;
        else return CLS_UNKNOWN;
    endfunction

    assign i_item.ready = i_rst_n && !i_full;
    assign accept       = i_item.valid && i_rst_n && !i_full;
    assign is_edge      = !i_item.opcode;
    assign dt           = i_item.edge_time - r_start;
    assign cls          = classify(i_cfg, dt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
            r_start  <= '0;
        end else if (accept && is_edge) begin
            r_parity <= ~r_parity;
            if (r_parity) begin
                r_start <= i_item.edge_time;
            end
        end
    end

    always_comb begin
        o_push         = accept;
        o_op.timeout   = i_item.opcode;
        o_op.measure   = is_edge && !r_parity;
        o_op.cls       = cls;
        o_op.leader    = (i_cfg.leader_low < dt) && (dt < i_cfg.leader_high);
    end

endmodule

FILE: design/nec_ir_fifo.sv
// ----------------------------------------------------------------------------
// nec_ir_fifo
// Short queue of decoded edge events between front and back.
// ----------------------------------------------------------------------------
module nec_ir_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nec_ir_pkg::t_op i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output nec_ir_pkg::t_op o_op
);
    import nec_ir_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/nec_ir_back.sv
// ----------------------------------------------------------------------------
// nec_ir_back
// Frame sequencer: symbol store, repeat counting, command check, result reg.
// ----------------------------------------------------------------------------
module nec_ir_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  nec_ir_pkg::t_op i_op,
    output logic            o_pop,
    nec_ir_out_if.source    o_result
);
    import nec_ir_pkg::*;

    localparam int SW       = $clog2(FRAME_SYMBOLS);
    localparam int IW       = SW + 1;
    localparam int CMD_BASE = 16;
    localparam int INV_BASE = 24;

    logic             r_armed,    n_armed;
    logic             r_leader,   n_leader;
    logic             r_rmode,    n_rmode;
    logic             r_complete, n_complete;
    logic [IW-1:0]    r_idx,      n_idx;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic [1:0]       r_store [FRAME_SYMBOLS];
    logic [1:0]       n_store [FRAME_SYMBOLS];

    logic             r_out_valid;
    logic             r_done, n_done;
    logic             r_rep,  n_rep;
    logic [CMD_W-1:0] r_cmd,  n_cmd;
    logic             r_ok,   n_ok;
    logic [CMD_W-1:0] acc;

    assign o_pop = !i_empty && (!r_out_valid || o_result.ready);

    always_comb begin
        n_armed    = r_armed;
        n_leader   = r_leader;
        n_rmode    = r_rmode;
        n_complete = r_complete;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_store    = r_store;
        n_done     = 1'b0;
        n_rep      = 1'b0;
        if (i_op.timeout) begin
            n_armed    = 1'b0;
            n_leader   = 1'b0;
            n_rmode    = 1'b0;
            n_complete = 1'b0;
            n_idx      = '0;
        end else begin
            if (i_op.measure) begin
                if (r_armed) begin
                    if (r_leader) begin
                        if (!r_rmode) begin
                            n_store[r_idx[SW-1:0]] = i_op.cls;
                            n_idx = r_idx + 1'b1;
                        end
                    end else if (i_op.leader) begin
                        n_leader = 1'b1;
                    end
                end else if (!r_rmode) begin
                    n_armed = 1'b1;
                end else if (i_op.cls == CLS_REPEAT) begin
                    n_cnt = r_cnt + 1'b1;
                    n_rep = 1'b1;
                end
            end
            if (n_idx == IW'(FRAME_SYMBOLS)) begin
                n_idx      = '0;
                n_armed    = 1'b0;
                n_rmode    = 1'b1;
                n_complete = 1'b1;
                n_done     = 1'b1;
            end
        end
    end

    // command byte and inverse check on the updated store
    always_comb begin
        n_ok = 1'b1;
        acc  = '0;
        for (int i = 0; i < CMD_W; i++) begin
            if (n_store[CMD_BASE + i] == n_store[INV_BASE + i]) begin
                n_ok = 1'b0;
            end
            acc = {acc[CMD_W-2:0], 1'b0} + {{(CMD_W-2){1'b0}}, n_store[CMD_BASE + i]};
        end
        n_cmd = n_ok ? acc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_leader    <= 1'b0;
            r_rmode     <= 1'b0;
            r_complete  <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FRAME_SYMBOLS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_armed    <= n_armed;
                r_leader   <= n_leader;
                r_rmode    <= n_rmode;
                r_complete <= n_complete;
                r_idx      <= n_idx;
                r_cnt      <= n_cnt;
                r_store    <= n_store;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done <= n_done;
            r_rep  <= n_rep;
            r_cmd  <= n_cmd;
            r_ok   <= n_ok;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.frame_done     = r_done;
    assign o_result.frame_complete = r_complete;
    assign o_result.command        = r_cmd;
    assign o_result.command_ok     = r_ok;
    assign o_result.repeat_seen    = r_rep;
    assign o_result.repeat_count   = r_cnt;

endmodule

FILE: design/nec_ir_pulse_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder
// NEC-style IR decoder working on capture-timer edge timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one edge item per handshake: opcode 0 is an edge with its
//   16-bit capture time, opcode 1 an external timeout that drops frame state.
//   o_result returns exactly one result item per input item, in order.
//   Classification windows sit in an APB register file, 4 bytes per register;
//   write them only while the decoder is idle (the block does not enforce it).
// Timing:
//   The front stage classifies the interval in the accept cycle and queues
//   the event; the back stage pops it, updates frame state and fills the
//   result register, which drives result valid. One item per cycle is
//   sustained while o_result is ready.
// Reset:
//   Windows return to their default values; parity, start time, frame flags,
//   symbol store and repeat counter clear; queue and result register empty.
// Stall:
//   When o_result is held, the queue absorbs FIFO_DEPTH more items before
//   i_item.ready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nec_ir_in_if.sink                     i_item,
    nec_ir_out_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nec_ir_pkg::APB_AW-1:0] paddr,
    input  logic [nec_ir_pkg::APB_DW-1:0] pwdata,
    output logic [nec_ir_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import nec_ir_pkg::*;

    t_cfg cfg;
    t_op  front_op;
    t_op  back_op;
    logic push;
    logic pop;
    logic full;
    logic empty;

    nec_ir_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nec_ir_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_op    (front_op)
    );

    nec_ir_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_op    (back_op)
    );

    nec_ir_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_op     (back_op),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
